/* design/sgp_pkg.sv */
// ----------------------------------------------------------------------------
// sgp_pkg: shared constants for the staggered-grid prolongation core
// Register indexes, port widths and result-slot codes used by the core and
// its checker.
// ----------------------------------------------------------------------------
package sgp_pkg;

   // Fine grid coordinates are reported modulo 512
   localparam int INDEX_WIDTH = 9;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_INTERVALS    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLUMN_INTERVALS = 4'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] RESET_INTERVALS = 8'd4;

   // Result slots of one item: odd row pair then even row pair
   localparam int SLOT_COUNT = 4;
   typedef logic [1:0] slot_idx_type;

   localparam slot_idx_type LAST_SLOT_EVEN_ONLY = 2'd1;
   localparam slot_idx_type LAST_SLOT_FULL      = 2'd3;

endpackage

/* design/sgp_req_if.sv */
// ----------------------------------------------------------------------------
// sgp_req_if: coarse sample channel
// Valid/ready channel carrying one signed coarse grid sample per item.
// ----------------------------------------------------------------------------
interface sgp_req_if #(
   parameter int VALUE_WIDTH = 32
) ();

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] coarse_value;

   modport source (output valid, output coarse_value, input ready);
   modport sink   (input valid, input coarse_value, output ready);

endinterface

/* design/sgp_rsp_if.sv */
// ----------------------------------------------------------------------------
// sgp_rsp_if: fine grid result channel
// Valid/ready channel carrying one fine grid value with its coordinates.
// ----------------------------------------------------------------------------
interface sgp_rsp_if #(
   parameter int VALUE_WIDTH = 32
) ();
   import sgp_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [INDEX_WIDTH-1:0]        fine_row;
   logic [INDEX_WIDTH-1:0]        fine_col;
   logic signed [VALUE_WIDTH-1:0] fine_value;
   logic                          run_last;
   logic                          grid_done;

   modport source (output valid, output fine_row, output fine_col, output fine_value,
                   output run_last, output grid_done, input ready);
   modport sink   (input valid, input fine_row, input fine_col, input fine_value,
                   input run_last, input grid_done, output ready);

endinterface

/* design/staggered_grid_prolongation_core.sv */
// ----------------------------------------------------------------------------
// staggered_grid_prolongation_core: streaming multigrid prolongation
// Takes a coarse grid in row-major order and emits the linearly prolonged
// fine grid on a staggered layout, one fine value per result item.
// ----------------------------------------------------------------------------
// Every accepted coarse sample is held in the input register, where the
// even-row pair and, from coarse row 1 on, the odd-row pair are formed
// against the line store; the results then leave through a four-slot result
// register at one per cycle while the result port is ready. An item passes
// through the input register and then the result register before its first
// result appears on the result port. A sample at coarse column 0 gives no
// result, one in coarse row 0 gives two and any other gives four, so inside
// the grid the item rate is set by the single result port.
// The next item is taken while the current group still drains. A write to
// either interval register restarts the grid at coarse row 0; write only
// while the block is idle.
module staggered_grid_prolongation_core
   import sgp_pkg::*;
#(
   parameter int MAX_ROW_INTERVALS    = 255,
   parameter int MAX_COLUMN_INTERVALS = 255,
   parameter int VALUE_WIDTH          = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   sgp_req_if.sink                    req_if,
   sgp_rsp_if.source                  rsp_if
);

   localparam int RW         = $clog2(MAX_ROW_INTERVALS + 1);
   localparam int CW         = $clog2(MAX_COLUMN_INTERVALS + 2);
   localparam int LINE_DEPTH = MAX_COLUMN_INTERVALS + 1;
   localparam int LW         = $clog2(LINE_DEPTH);
   localparam int W          = VALUE_WIDTH;

   // Configuration and grid position
   logic [CSR_DATA_WIDTH-1:0] row_intervals_ff, row_intervals_in;
   logic [CSR_DATA_WIDTH-1:0] column_intervals_ff, column_intervals_in;
   logic [RW-1:0]             row_counter_ff, row_counter_in;
   logic [CW-1:0]             column_counter_ff, column_counter_in;
   logic [W-1:0]              previous_coarse_ff, previous_coarse_in;

   logic [RW-1:0] nx_eff;
   logic [CW-1:0] ny_eff;
   logic [CW-1:0] last_col;
   logic          req_fire;
   logic          row_end;

   // Input register
   logic          s1_valid_ff, s1_valid_in;
   logic [W-1:0]  s1_value_ff;
   logic [W-1:0]  s1_prev_ff;
   logic [RW-1:0] s1_row_ff;
   logic [LW-1:0] s1_j_ff;
   logic          s1_has_pair_ff;
   logic          s1_done_ff;

   // Line store of even-row pairs, one entry per coarse column pair
   logic [2*W-1:0] line_mem [LINE_DEPTH];
   logic [2*W-1:0] line_rd_ff;
   logic [LW-1:0]  rd_idx;

   // Result register
   logic                   grp_valid_ff, grp_valid_in;
   slot_idx_type           grp_idx_ff, grp_idx_in;
   slot_idx_type           grp_last_ff;
   logic                   grp_done_ff;
   logic                   grp_has_odd_ff;
   logic [INDEX_WIDTH-1:0] grp_even_row_ff;
   logic [INDEX_WIDTH-1:0] grp_odd_row_ff;
   logic [INDEX_WIDTH-1:0] grp_col0_ff;
   logic [W-1:0]           grp_value_ff [SLOT_COUNT];

   logic grp_free;
   logic s1_move;
   logic grp_load;
   logic rsp_fire;

   // Datapath of the input register
   logic signed [W+1:0] sum_e0, sum_e1;
   logic signed [W:0]   sum_o0, sum_o1;
   logic [W-1:0]        e0, e1, o0, o1;
   logic [W-1:0]        up0, up1;
   logic [RW:0]         even_row_wide;
   logic [RW:0]         odd_row_wide;

   // Saturate the interval registers to the sized range
   assign nx_eff = (int'(row_intervals_ff) > MAX_ROW_INTERVALS) ?
                   RW'(MAX_ROW_INTERVALS) : RW'(row_intervals_ff);
   assign ny_eff = (int'(column_intervals_ff) > MAX_COLUMN_INTERVALS) ?
                   CW'(MAX_COLUMN_INTERVALS) : CW'(column_intervals_ff);
   assign last_col = ny_eff + CW'(1);
   assign row_end  = (column_counter_ff >= last_col);

   // Handshake
   assign rsp_fire     = grp_valid_ff && rsp_if.ready;
   assign grp_free     = !grp_valid_ff || (rsp_fire && (grp_idx_ff == grp_last_ff));
   assign s1_move      = s1_valid_ff && grp_free;
   assign grp_load     = s1_move && s1_has_pair_ff;
   assign req_if.ready = !s1_valid_ff || grp_free;
   assign req_fire     = req_if.valid && req_if.ready;

   // Configuration writes and grid position
   always_comb begin
      row_intervals_in    = row_intervals_ff;
      column_intervals_in = column_intervals_ff;
      row_counter_in      = row_counter_ff;
      column_counter_in   = column_counter_ff;
      previous_coarse_in  = previous_coarse_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_ROW_INTERVALS: begin
               row_intervals_in  = csr_write_data;
               row_counter_in    = '0;
               column_counter_in = '0;
            end
            REG_COLUMN_INTERVALS: begin
               column_intervals_in = csr_write_data;
               row_counter_in      = '0;
               column_counter_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (req_fire) begin
         previous_coarse_in = req_if.coarse_value;
         if (row_end) begin
            column_counter_in = '0;
            row_counter_in    = (row_counter_ff >= nx_eff) ? '0 : row_counter_ff + RW'(1);
         end else begin
            column_counter_in = column_counter_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_intervals_ff    <= RESET_INTERVALS;
         column_intervals_ff <= RESET_INTERVALS;
         row_counter_ff      <= '0;
         column_counter_ff   <= '0;
         previous_coarse_ff  <= '0;
      end else begin
         row_intervals_ff    <= row_intervals_in;
         column_intervals_ff <= column_intervals_in;
         row_counter_ff      <= row_counter_in;
         column_counter_ff   <= column_counter_in;
         previous_coarse_ff  <= previous_coarse_in;
      end
   end

   // Input register: valid advances when the item moves on
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign rd_idx = LW'(column_counter_ff - CW'(1));

   // Capture the item, its position and the line entry it pairs with
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_value_ff    <= req_if.coarse_value;
         s1_prev_ff     <= previous_coarse_ff;
         s1_row_ff      <= row_counter_ff;
         s1_j_ff        <= rd_idx;
         s1_has_pair_ff <= (column_counter_ff != '0);
         s1_done_ff     <= (row_counter_ff >= nx_eff) && row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (column_counter_ff != '0)) begin
         line_rd_ff <= line_mem[rd_idx];
      end
   end

   // Write back the even-row pair as the item leaves
   always_ff @(posedge clock) begin
      if (grp_load) begin
         line_mem[s1_j_ff] <= {e1, e0};
      end
   end

   // Even row: floor((3a+b)/4) and floor((a+3b)/4), exact before the shift
   always_comb begin
      sum_e0 = {{2{s1_prev_ff[W-1]}}, s1_prev_ff}
             + {{1{s1_prev_ff[W-1]}}, s1_prev_ff, 1'b0}
             + {{2{s1_value_ff[W-1]}}, s1_value_ff};
      sum_e1 = {{2{s1_value_ff[W-1]}}, s1_value_ff}
             + {{1{s1_value_ff[W-1]}}, s1_value_ff, 1'b0}
             + {{2{s1_prev_ff[W-1]}}, s1_prev_ff};
      e0 = sum_e0[W+1:2];
      e1 = sum_e1[W+1:2];
   end

   // Odd row: floor average of the stored even row and this one
   always_comb begin
      up0    = line_rd_ff[W-1:0];
      up1    = line_rd_ff[2*W-1:W];
      sum_o0 = {up0[W-1], up0} + {e0[W-1], e0};
      sum_o1 = {up1[W-1], up1} + {e1[W-1], e1};
      o0     = sum_o0[W:1];
      o1     = sum_o1[W:1];
   end

   assign even_row_wide = {s1_row_ff, 1'b0};
   assign odd_row_wide  = even_row_wide - (RW + 1)'(1);

   // Result register: load a group, then step through its slots
   always_comb begin
      grp_valid_in = grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      if (grp_load) begin
         grp_valid_in = 1'b1;
         grp_idx_in   = '0;
      end else if (grp_free) begin
         grp_valid_in = 1'b0;
      end else if (rsp_fire) begin
         grp_idx_in = grp_idx_ff + slot_idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= '0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_done_ff     <= s1_done_ff;
         grp_has_odd_ff  <= (s1_row_ff != '0);
         grp_even_row_ff <= INDEX_WIDTH'(even_row_wide);
         grp_odd_row_ff  <= INDEX_WIDTH'(odd_row_wide);
         grp_col0_ff     <= INDEX_WIDTH'({s1_j_ff, 1'b0});
         if (s1_row_ff != '0) begin
            grp_last_ff     <= LAST_SLOT_FULL;
            grp_value_ff[0] <= o0;
            grp_value_ff[1] <= o1;
            grp_value_ff[2] <= e0;
            grp_value_ff[3] <= e1;
         end else begin
            grp_last_ff     <= LAST_SLOT_EVEN_ONLY;
            grp_value_ff[0] <= e0;
            grp_value_ff[1] <= e1;
            grp_value_ff[2] <= e0;
            grp_value_ff[3] <= e1;
         end
      end
   end

   // Drive the result channel from the current slot
   assign rsp_if.valid      = grp_valid_ff;
   assign rsp_if.fine_row   = (grp_has_odd_ff && !grp_idx_ff[1]) ?
                              grp_odd_row_ff : grp_even_row_ff;
   assign rsp_if.fine_col   = {grp_col0_ff[INDEX_WIDTH-1:1], grp_idx_ff[0]};
   assign rsp_if.fine_value = grp_value_ff[grp_idx_ff];
   assign rsp_if.run_last   = (grp_idx_ff == grp_last_ff);
   assign rsp_if.grid_done  = (grp_idx_ff == grp_last_ff) && grp_done_ff;

endmodule

/* design/sgp_checker.sv */
// ----------------------------------------------------------------------------
// sgp_checker: port-level checks for the prolongation core
// Watches the result channel of the core and flags handshake and framing slips.
// ----------------------------------------------------------------------------
module sgp_checker
   import sgp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [INDEX_WIDTH-1:0] rsp_fine_row,
   input logic [INDEX_WIDTH-1:0] rsp_fine_col,
   input logic [VALUE_WIDTH-1:0] rsp_fine_value,
   input logic                   rsp_run_last,
   input logic                   rsp_grid_done
);

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fine_row)
         && $stable(rsp_fine_col) && $stable(rsp_fine_value))
      else $error("stalled result item changed");

   // Close the grid only on the last item of a run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_done |-> rsp_run_last)
      else $error("grid_done without run_last");

   // End each run at an odd fine column
   a_last_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_fine_col[0])
      else $error("run ended at an even fine column");

   // Drop results during reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid right after reset");

endmodule

bind staggered_grid_prolongation_core sgp_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_sgp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_fine_row   (rsp_if.fine_row),
   .rsp_fine_col   (rsp_if.fine_col),
   .rsp_fine_value (rsp_if.fine_value),
   .rsp_run_last   (rsp_if.run_last),
   .rsp_grid_done  (rsp_if.grid_done)
);

/* tb/sv/staggered_grid_prolongation_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// staggered_grid_prolongation_core_tb: self-checking bench for the core
// Streams coarse grids through the core and checks every fine grid item. A
// short directed table covers extreme samples, zero and full-size intervals,
// grid wrap and the ignored register index. Random phases of whole and cut
// grids follow. A line-buffer model of the prolongation predicts each result.
// ----------------------------------------------------------------------------
module staggered_grid_prolongation_core_tb;
   import sgp_pkg::*;

   localparam int VALUE_WIDTH   = 32;
   localparam int LINE_DEPTH    = 512;
   localparam int IDLE_PERCENT  = 26;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int RANDOM_ITEMS  = 90;
   localparam int RUN_LIMIT_NS  = 4_000_000;

   // Index that decodes to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = 4'd7;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type              kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [31:0]                data;
      logic                       typed;
      logic [31:0]                even_lo;
      logic [31:0]                even_hi;
   } directed_step_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] row;
      logic [INDEX_WIDTH-1:0] col;
      logic [31:0]            value;
      logic                   run_last;
      logic                   grid_done;
   } fine_item_type;

   localparam int DIRECTED_LEN = 31;

   // Directed stimulus; typed rows give the even-row pair of that item
   directed_step_type directed_plan [DIRECTED_LEN] = '{
      // reset intervals, extreme samples along coarse row 0 and into row 1
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h8000_0000, 1'b1, 32'h3FFF_FFFF, 32'hBFFF_FFFF},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h0000_0000, 1'b1, 32'hA000_0000, 32'hE000_0000},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h0000_0003, 1'b0, 32'h0, 32'h0},
      // zero intervals: one row, two columns, then wrap
      '{STEP_CSR, REG_ROW_INTERVALS, 32'd0, 1'b0, 32'h0, 32'h0},
      '{STEP_CSR, REG_COLUMN_INTERVALS, 32'd0, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFE},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h1234_5678, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hEDCB_A988, 1'b0, 32'h0, 32'h0},
      // smallest grid with an odd row, full-scale swing between rows
      '{STEP_CSR, REG_ROW_INTERVALS, 32'd1, 1'b0, 32'h0, 32'h0},
      '{STEP_CSR, REG_COLUMN_INTERVALS, 32'd1, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000},
      // largest intervals
      '{STEP_CSR, REG_ROW_INTERVALS, 32'd255, 1'b0, 32'h0, 32'h0},
      '{STEP_CSR, REG_COLUMN_INTERVALS, 32'd255, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h0000_0003, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hFFFF_FFFD, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h0000_0005, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hFFFF_FFF9, 1'b0, 32'h0, 32'h0},
      // unused index must leave the grid position alone
      '{STEP_CSR, REG_SPARE, 32'hA5, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'h4000_0000, 1'b0, 32'h0, 32'h0},
      '{STEP_ITEM, REG_ROW_INTERVALS, 32'hC000_0000, 1'b0, 32'h0, 32'h0}
   };

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;
   logic                       steady_mode      = 1'b0;
   int                         mismatch_count   = 0;
   fine_item_type              fine_expect_q [$];

   // Prolongation model state
   logic [31:0] held_coarse = '0;
   logic [31:0] even_line [LINE_DEPTH];
   logic [7:0]  row_pos  = '0;
   logic [8:0]  col_pos  = '0;
   logic [7:0]  rows_cfg = RESET_INTERVALS;
   logic [7:0]  cols_cfg = RESET_INTERVALS;

   sgp_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
   sgp_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_ch ();

   staggered_grid_prolongation_core #(
      .MAX_ROW_INTERVALS   (255),
      .MAX_COLUMN_INTERVALS(255),
      .VALUE_WIDTH         (VALUE_WIDTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor((3*near + far) / 4), formed exactly on 34 bits
   function automatic logic [31:0] quarter_blend(input logic [31:0] near, input logic [31:0] far);
      logic [33:0] acc;
      acc = {{2{near[31]}}, near} * 34'd3 + {{2{far[31]}}, far};
      return acc[33:2];
   endfunction

   // floor((up + down) / 2), formed exactly on 33 bits
   function automatic logic [31:0] mid_value(input logic [31:0] up, input logic [31:0] down);
      logic [32:0] acc;
      acc = {up[31], up} + {down[31], down};
      return acc[32:1];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Queue the fine items one coarse sample causes and advance the grid position
   task automatic prolong_coarse_sample(input logic [31:0] sample);
      int          j;
      int          fine_even;
      logic [8:0]  c0;
      logic [8:0]  c1;
      logic [31:0] e0;
      logic [31:0] e1;
      logic        last_in_grid;
      if (col_pos != 0) begin
         j         = int'(col_pos) - 1;
         c0        = 9'(2 * j);
         c1        = 9'(2 * j + 1);
         e0        = quarter_blend(held_coarse, sample);
         e1        = quarter_blend(sample, held_coarse);
         fine_even = 2 * int'(row_pos);
         last_in_grid = (row_pos >= rows_cfg) && (int'(col_pos) >= int'(cols_cfg) + 1);
         if (row_pos != 0) begin
            fine_expect_q.push_back(fine_item_type'{9'(fine_even - 1), c0,
                                    mid_value(even_line[c0], e0), 1'b0, 1'b0});
            fine_expect_q.push_back(fine_item_type'{9'(fine_even - 1), c1,
                                    mid_value(even_line[c1], e1), 1'b0, 1'b0});
         end
         even_line[c0] = e0;
         even_line[c1] = e1;
         fine_expect_q.push_back(fine_item_type'{9'(fine_even), c0, e0, 1'b0, 1'b0});
         fine_expect_q.push_back(fine_item_type'{9'(fine_even), c1, e1, 1'b1, last_in_grid});
      end
      held_coarse = sample;
      if (int'(col_pos) >= int'(cols_cfg) + 1) begin
         col_pos = '0;
         row_pos = (row_pos >= rows_cfg) ? 8'd0 : row_pos + 8'd1;
      end else begin
         col_pos = col_pos + 9'd1;
      end
   endtask

   // Offer one coarse item, idling at random first outside steady mode; entered and left at a falling edge
   task automatic send_coarse(input logic [31:0] sample, input logic typed,
                              input logic [31:0] even_lo, input logic [31:0] even_hi);
      int tail;
      while (!steady_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.coarse_value <= sample;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      prolong_coarse_sample(sample);
      // pin the even pair to the hand-worked values
      if (typed) begin
         tail = fine_expect_q.size();
         fine_expect_q[tail - 2].value = even_lo;
         fine_expect_q[tail - 1].value = even_hi;
      end
      @(negedge clock);
   endtask

   // Drain the core, let it settle, then write one register
   task automatic write_interval(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [7:0] data);
      req_ch.valid <= 1'b0;
      while (fine_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         REG_ROW_INTERVALS: begin
            rows_cfg = data;
            row_pos  = '0;
            col_pos  = '0;
         end
         REG_COLUMN_INTERVALS: begin
            cols_cfg = data;
            row_pos  = '0;
            col_pos  = '0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side backpressure
   always @(negedge clock) begin
      rsp_ch.ready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      fine_item_type seen;
      fine_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = fine_item_type'{rsp_ch.fine_row, rsp_ch.fine_col, rsp_ch.fine_value,
                                rsp_ch.run_last, rsp_ch.grid_done};
         if (fine_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item row %0d col %0d value %h",
                                      seen.row, seen.col, seen.value));
         end else begin
            want = fine_expect_q.pop_front();
            if (seen !== want) begin
               report_mismatch($sformatf(
                  "row %0d/%0d col %0d/%0d value %h/%h last %b/%b done %b/%b (got/exp)",
                  seen.row, want.row, seen.col, want.col, seen.value, want.value,
                  seen.run_last, want.run_last, seen.grid_done, want.grid_done));
            end
         end
      end
   end

   initial begin
      int          small_items;
      int          phase_no;
      int          nx;
      int          ny;
      int          grid_items;
      int          item_count;
      int          spare_at;
      logic        keep_rows;
      logic        big_phase;
      logic [31:0] sample;
      req_ch.valid        = 1'b0;
      req_ch.coarse_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CSR) begin
            write_interval(directed_plan[i].index, directed_plan[i].data[7:0]);
         end else begin
            send_coarse(directed_plan[i].data, directed_plan[i].typed,
                        directed_plan[i].even_lo, directed_plan[i].even_hi);
         end
      end

      // Random phases: mostly whole grids, some cut short
      small_items = 0;
      phase_no    = 0;
      while (small_items < RANDOM_ITEMS || phase_no < 4) begin
         phase_no++;
         big_phase = (phase_no == 2) || (phase_no == 4);
         keep_rows = 1'b0;
         if (phase_no == 2) begin
            // tall grid sets the high fine row bits
            nx = $urandom_range(64, 67);
            ny = 0;
         end else if (phase_no == 4) begin
            // wide grid reaches the upper fine columns
            nx = 0;
            ny = $urandom_range(128, 131);
         end else begin
            nx = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            ny = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            keep_rows = ($urandom_range(0, 3) == 0) && (rows_cfg <= 8'd12);
            if (keep_rows) nx = int'(rows_cfg);
         end
         grid_items = (nx + 1) * (ny + 2);
         if (big_phase) begin
            item_count = grid_items;
         end else if ($urandom_range(0, 4) == 0) begin
            item_count = $urandom_range(1, grid_items);
         end else begin
            item_count = grid_items * $urandom_range(1, 2);
         end
         if (!big_phase) small_items += item_count;
         spare_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, item_count) : -1;

         if (!keep_rows) write_interval(REG_ROW_INTERVALS, 8'(nx));
         write_interval(REG_COLUMN_INTERVALS, 8'(ny));
         // hold both sides busy through the tall grid
         if (phase_no == 2) steady_mode <= 1'b1;

         for (int k = 0; k < item_count; k++) begin
            if (k == spare_at) write_interval(REG_SPARE, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
               0:       sample = 32'h7FFF_FFFF;
               1:       sample = 32'h8000_0000;
               2:       sample = 32'($urandom_range(0, 15)) - 32'd8;
               default: sample = $urandom;
            endcase
            send_coarse(sample, 1'b0, '0, '0);
         end
         steady_mode <= 1'b0;
      end

      // Drain and let the pipeline settle
      req_ch.valid <= 1'b0;
      while (fine_expect_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** staggered_grid_prolongation_core: PASSED **");
      end else begin
         $display("** staggered_grid_prolongation_core: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("** staggered_grid_prolongation_core: FAILED **");
      $finish;
   end

endmodule
